[sv/bhc_pkg.sv]
`default_nettype none

package bhc_pkg;

   localparam int DUTY_W   = 13;
   localparam int PWM_W    = 16;
   localparam int PP_W     = 8;
   localparam int TIME_W   = 32;
   localparam int RPM_W    = 15;
   localparam int NUM_W    = 24;
   localparam int PROD_W   = TIME_W + PP_W;
   localparam int PULSE_W  = DUTY_W + PWM_W;
   localparam int CNT_W    = 5;

   localparam logic [DUTY_W-1:0] DUTY_FULL      = 13'd4096;
   localparam logic [NUM_W-1:0]  RPM_NUMERATOR  = 24'd10000000;
   localparam logic [PWM_W-1:0]  PWM_PERIOD_RST = 16'd1000;
   localparam logic [PP_W-1:0]   PPAIR_RST      = 8'd4;
   localparam logic [PP_W-1:0]   PPAIR_DEF      = 8'd4;

   localparam logic [2:0] CMD_START      = 3'd0;
   localparam logic [2:0] CMD_STOP       = 3'd1;
   localparam logic [2:0] CMD_SET_DUTY   = 3'd2;
   localparam logic [2:0] CMD_HALL_EDGE  = 3'd3;
   localparam logic [2:0] CMD_BREAK      = 3'd4;
   localparam logic [2:0] CMD_CLEAR      = 3'd5;

   localparam logic [1:0] RUN_STOPPED = 2'd0;
   localparam logic [1:0] RUN_RUNNING = 2'd1;
   localparam logic [1:0] RUN_FAULT   = 2'd2;

   localparam logic CSR_PWM_PERIOD = 1'b0;
   localparam logic CSR_PPAIR      = 1'b1;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_CALC,
      CTL_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      SPD_IDLE,
      SPD_MUL,
      SPD_DIV
   } spd_state_type;

   typedef struct packed {
      logic             busy;
      logic [RPM_W-1:0] rpm;
   } spd_rsp_type;

   // gate bits UH,UL,VH,VL,WH,WL; hall codes 0 and 7 are all off
   function automatic logic [5:0] step_pattern(input logic rev, input logic [2:0] hall);
      logic [5:0] pat;
      if (rev) begin
         case (hall)
            3'd1:    pat = 6'h18;
            3'd2:    pat = 6'h28;
            3'd3:    pat = 6'h12;
            3'd4:    pat = 6'h24;
            3'd5:    pat = 6'h06;
            3'd6:    pat = 6'h21;
            default: pat = 6'h00;
         endcase
      end else begin
         case (hall)
            3'd1:    pat = 6'h24;
            3'd2:    pat = 6'h06;
            3'd3:    pat = 6'h21;
            3'd4:    pat = 6'h18;
            3'd5:    pat = 6'h09;
            3'd6:    pat = 6'h12;
            default: pat = 6'h00;
         endcase
      end
      return pat;
   endfunction

endpackage

`default_nettype wire

[sv/bhc_speed_unit.sv]
`default_nettype none

module bhc_speed_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire  [bhc_pkg::TIME_W-1:0]         period,
   input  wire  [bhc_pkg::PP_W-1:0]           ppair,
   output bhc_pkg::spd_rsp_type               rsp
);

   bhc_pkg::spd_state_type            state_ff, state_in;
   logic [bhc_pkg::PROD_W-1:0]        mcand_ff, mcand_in;
   logic [bhc_pkg::PP_W-1:0]          mplier_ff, mplier_in;
   logic [bhc_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [bhc_pkg::NUM_W-1:0]         num_ff, num_in;
   logic [bhc_pkg::NUM_W-1:0]         rem_ff, rem_in;
   logic [bhc_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic [bhc_pkg::CNT_W-1:0]         cnt_ff, cnt_in;

   logic [bhc_pkg::NUM_W:0]           rem_sh;
   logic [bhc_pkg::NUM_W:0]           rem_sub;
   logic                              div_fits;
   logic [bhc_pkg::RPM_W-1:0]         rpm_sat;

   // restoring divide, one quotient bit per cycle; remainder stays below 2^24
   assign rem_sh   = {rem_ff, num_ff[bhc_pkg::NUM_W-1]};
   assign div_fits = (prod_ff[bhc_pkg::PROD_W-1:bhc_pkg::NUM_W+1] == '0) &&
                     (rem_sh >= prod_ff[bhc_pkg::NUM_W:0]);
   assign rem_sub  = rem_sh - prod_ff[bhc_pkg::NUM_W:0];

   always_comb begin
      state_in  = state_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         bhc_pkg::SPD_IDLE: begin
            if (start) begin
               mcand_in  = {{bhc_pkg::PP_W{1'b0}}, period};
               mplier_in = ppair;
               prod_in   = '0;
               state_in  = bhc_pkg::SPD_MUL;
            end
         end
         bhc_pkg::SPD_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (mplier_ff[bhc_pkg::PP_W-1:1] == '0) begin
               num_in   = bhc_pkg::RPM_NUMERATOR;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = bhc_pkg::CNT_W'(bhc_pkg::NUM_W - 1);
               state_in = bhc_pkg::SPD_DIV;
            end
         end
         bhc_pkg::SPD_DIV: begin
            rem_in = div_fits ? rem_sub[bhc_pkg::NUM_W-1:0] : rem_sh[bhc_pkg::NUM_W-1:0];
            quo_in = {quo_ff[bhc_pkg::NUM_W-2:0], div_fits};
            num_in = num_ff << 1;
            cnt_in = cnt_ff - bhc_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = bhc_pkg::SPD_IDLE;
            end
         end
         default: begin
            state_in = bhc_pkg::SPD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhc_pkg::SPD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

   assign rpm_sat = (quo_ff[bhc_pkg::NUM_W-1:bhc_pkg::RPM_W] != '0) ?
                    {bhc_pkg::RPM_W{1'b1}} : quo_ff[bhc_pkg::RPM_W-1:0];
   assign rsp     = {(state_ff != bhc_pkg::SPD_IDLE), rpm_sat};

endmodule

`default_nettype wire

[sv/bldc_hall_six_step_commutator_core.sv]
// Six-step BLDC commutator driven by hall edge events.
// Request channel (req_valid/req_stall): one command with hall code, timer
// stamp, direction and duty. Each request yields exactly one response on the
// rsp_ channel (rsp_valid/rsp_stall): a snapshot of run state, compares, gate
// pattern, enables, speed, period and counters after the command.
// From request accept, each command passes the execute, calc and done states.
// Calc also holds for a commutation (13-step shift-add duty scaling) and
// for a hall edge that measures speed (8-step serial multiply of period by pole
// pairs, then a 24-step restoring divide). One request is in flight at a time;
// req_stall is high from accept until the response is registered, so a new
// request is taken while the previous response still waits on rsp_stall.
// A held response blocks the next one from being registered, not the request.
// csr_ writes (index 0 pwm_period, index 1 pole pair count) are always ready
// and should be issued while idle.
// Synchronous reset: stopped, forward, duty 0, counters 0, both output
// enables on, pwm_period 1000, 4 pole pairs, no response pending.
`default_nettype none

module bldc_hall_six_step_commutator_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [2:0]                       req_cmd,
   input  wire  [2:0]                       req_hall_code,
   input  wire  [31:0]                      req_timer_now,
   input  wire                              req_reverse,
   input  wire  [12:0]                      req_duty_in,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [1:0]                       rsp_run_state_out,
   output logic [15:0]                      rsp_compare_u,
   output logic [15:0]                      rsp_compare_v,
   output logic [15:0]                      rsp_compare_w,
   output logic [5:0]                       rsp_gate_pattern,
   output logic                             rsp_comp_outputs_on,
   output logic                             rsp_main_output_on,
   output logic signed [15:0]               rsp_speed_rpm_out,
   output logic [31:0]                      rsp_period_us_out,
   output logic [31:0]                      rsp_commutations,
   output logic [31:0]                      rsp_faults,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire                              csr_index,
   input  wire  [15:0]                      csr_wdata
);

   localparam int TW = bhc_pkg::TIME_W;
   localparam int PW = bhc_pkg::PULSE_W;

   bhc_pkg::ctl_state_type          ctl_ff, ctl_in;
   logic [1:0]                      run_ff, run_in;
   logic                            dir_ff, dir_in;
   logic [bhc_pkg::DUTY_W-1:0]      duty_ff, duty_in;
   logic [TW-1:0]                   last_ff, last_in;
   logic                            seen_ff, seen_in;
   logic [TW-1:0]                   period_ff, period_in;
   logic [15:0]                     speed_ff, speed_in;
   logic [TW-1:0]                   commut_ff, commut_in;
   logic [TW-1:0]                   fault_ff, fault_in;
   logic [15:0]                     cmp_u_ff, cmp_u_in;
   logic [15:0]                     cmp_v_ff, cmp_v_in;
   logic [15:0]                     cmp_w_ff, cmp_w_in;
   logic [5:0]                      gate_ff, gate_in;
   logic                            comp_en_ff, comp_en_in;
   logic                            main_en_ff, main_en_in;
   logic                            do_comm_ff, do_comm_in;
   logic                            do_spd_ff, do_spd_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bhc_pkg::PWM_W-1:0]       pwm_period_ff;
   logic [bhc_pkg::PP_W-1:0]        ppair_ff;

   // captured request
   logic [2:0]                      cmd_ff;
   logic [2:0]                      hall_ff;
   logic [TW-1:0]                   now_ff;
   logic                            rev_ff;
   logic [bhc_pkg::DUTY_W-1:0]      dsat_ff;

   // serial duty scaling
   logic [PW-1:0]                   pm_acc_ff, pm_acc_in;
   logic [PW-1:0]                   pm_mcand_ff, pm_mcand_in;
   logic [bhc_pkg::DUTY_W-1:0]      pm_mplier_ff, pm_mplier_in;
   logic [5:0]                      pat_ff, pat_in;

   // response payload
   logic [1:0]                      o_run_ff;
   logic [15:0]                     o_cmp_u_ff, o_cmp_v_ff, o_cmp_w_ff;
   logic [5:0]                      o_gate_ff;
   logic                            o_comp_ff, o_main_ff;
   logic [15:0]                     o_speed_ff;
   logic [TW-1:0]                   o_period_ff, o_commut_ff, o_fault_ff;

   logic                            req_accept;
   logic                            out_load;
   logic                            spd_start;
   logic [TW-1:0]                   edge_diff;
   logic [bhc_pkg::PP_W-1:0]        pp_eff;
   logic [15:0]                     pulse;
   logic [15:0]                     rpm_ext;
   logic [bhc_pkg::DUTY_W-1:0]      req_dsat;
   bhc_pkg::spd_rsp_type            spd_rsp;

   assign req_stall  = (ctl_ff != bhc_pkg::CTL_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = (ctl_ff == bhc_pkg::CTL_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready  = 1'b1;
   assign req_dsat   = (req_duty_in > bhc_pkg::DUTY_FULL) ? bhc_pkg::DUTY_FULL : req_duty_in;
   assign edge_diff  = now_ff - last_ff;
   assign pp_eff     = (ppair_ff == '0) ? bhc_pkg::PPAIR_DEF : ppair_ff;
   assign pulse      = pm_acc_ff[27:12];
   assign rpm_ext    = {1'b0, spd_rsp.rpm};

   bhc_speed_unit u_speed (
      .clock      (clock),
      .reset      (reset),
      .start      (spd_start),
      .period     (edge_diff),
      .ppair      (pp_eff),
      .rsp        (spd_rsp)
   );

   always_comb begin
      ctl_in       = ctl_ff;
      run_in       = run_ff;
      dir_in       = dir_ff;
      duty_in      = duty_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      period_in    = period_ff;
      speed_in     = speed_ff;
      commut_in    = commut_ff;
      fault_in     = fault_ff;
      cmp_u_in     = cmp_u_ff;
      cmp_v_in     = cmp_v_ff;
      cmp_w_in     = cmp_w_ff;
      gate_in      = gate_ff;
      comp_en_in   = comp_en_ff;
      main_en_in   = main_en_ff;
      do_comm_in   = do_comm_ff;
      do_spd_in    = do_spd_ff;
      pm_acc_in    = pm_acc_ff;
      pm_mcand_in  = pm_mcand_ff;
      pm_mplier_in = pm_mplier_ff;
      pat_in       = pat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      spd_start    = 1'b0;
      case (ctl_ff)
         bhc_pkg::CTL_IDLE: begin
            if (req_accept) begin
               ctl_in = bhc_pkg::CTL_EXEC;
            end
         end
         bhc_pkg::CTL_EXEC: begin
            do_comm_in   = 1'b0;
            do_spd_in    = 1'b0;
            pm_acc_in    = '0;
            pm_mcand_in  = {{bhc_pkg::DUTY_W{1'b0}}, pwm_period_ff};
            pm_mplier_in = '0;
            case (cmd_ff)
               bhc_pkg::CMD_START: begin
                  if (run_ff != bhc_pkg::RUN_FAULT) begin
                     dir_in       = rev_ff;
                     duty_in      = dsat_ff;
                     run_in       = bhc_pkg::RUN_RUNNING;
                     comp_en_in   = 1'b1;
                     do_comm_in   = 1'b1;
                     pat_in       = bhc_pkg::step_pattern(rev_ff, hall_ff);
                     pm_mplier_in = dsat_ff;
                  end
               end
               bhc_pkg::CMD_STOP: begin
                  run_in     = bhc_pkg::RUN_STOPPED;
                  duty_in    = '0;
                  cmp_u_in   = '0;
                  cmp_v_in   = '0;
                  cmp_w_in   = '0;
                  gate_in    = '0;
                  comp_en_in = 1'b0;
               end
               bhc_pkg::CMD_SET_DUTY: begin
                  duty_in = dsat_ff;
               end
               bhc_pkg::CMD_HALL_EDGE: begin
                  if (run_ff == bhc_pkg::RUN_RUNNING) begin
                     if (seen_ff) begin
                        period_in = edge_diff;
                        if (edge_diff != '0) begin
                           spd_start = 1'b1;
                           do_spd_in = 1'b1;
                        end
                     end
                     last_in      = now_ff;
                     seen_in      = 1'b1;
                     do_comm_in   = 1'b1;
                     pat_in       = bhc_pkg::step_pattern(dir_ff, hall_ff);
                     pm_mplier_in = duty_ff;
                  end
               end
               bhc_pkg::CMD_BREAK: begin
                  run_in     = bhc_pkg::RUN_FAULT;
                  fault_in   = fault_ff + TW'(1);
                  speed_in   = '0;
                  duty_in    = '0;
                  main_en_in = 1'b0;
               end
               bhc_pkg::CMD_CLEAR: begin
                  if (run_ff == bhc_pkg::RUN_FAULT) begin
                     main_en_in = 1'b1;
                     run_in     = bhc_pkg::RUN_STOPPED;
                  end
               end
               default: begin
               end
            endcase
            ctl_in = bhc_pkg::CTL_CALC;
         end
         bhc_pkg::CTL_CALC: begin
            if (pm_mplier_ff != '0) begin
               if (pm_mplier_ff[0]) begin
                  pm_acc_in = pm_acc_ff + pm_mcand_ff;
               end
               pm_mcand_in  = pm_mcand_ff << 1;
               pm_mplier_in = pm_mplier_ff >> 1;
            end else if (!spd_rsp.busy) begin
               if (do_comm_ff) begin
                  cmp_u_in  = pat_ff[5] ? pulse : 16'd0;
                  cmp_v_in  = pat_ff[3] ? pulse : 16'd0;
                  cmp_w_in  = pat_ff[1] ? pulse : 16'd0;
                  gate_in   = pat_ff;
                  commut_in = commut_ff + TW'(1);
               end
               if (do_spd_ff) begin
                  speed_in = dir_ff ? (16'd0 - rpm_ext) : rpm_ext;
               end
               ctl_in = bhc_pkg::CTL_DONE;
            end
         end
         bhc_pkg::CTL_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               ctl_in       = bhc_pkg::CTL_IDLE;
            end
         end
         default: begin
            ctl_in = bhc_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= bhc_pkg::CTL_IDLE;
         run_ff        <= bhc_pkg::RUN_STOPPED;
         dir_ff        <= 1'b0;
         duty_ff       <= '0;
         last_ff       <= '0;
         seen_ff       <= 1'b0;
         period_ff     <= '0;
         speed_ff      <= '0;
         commut_ff     <= '0;
         fault_ff      <= '0;
         cmp_u_ff      <= '0;
         cmp_v_ff      <= '0;
         cmp_w_ff      <= '0;
         gate_ff       <= '0;
         comp_en_ff    <= 1'b1;
         main_en_ff    <= 1'b1;
         do_comm_ff    <= 1'b0;
         do_spd_ff     <= 1'b0;
         pm_mplier_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_ff        <= ctl_in;
         run_ff        <= run_in;
         dir_ff        <= dir_in;
         duty_ff       <= duty_in;
         last_ff       <= last_in;
         seen_ff       <= seen_in;
         period_ff     <= period_in;
         speed_ff      <= speed_in;
         commut_ff     <= commut_in;
         fault_ff      <= fault_in;
         cmp_u_ff      <= cmp_u_in;
         cmp_v_ff      <= cmp_v_in;
         cmp_w_ff      <= cmp_w_in;
         gate_ff       <= gate_in;
         comp_en_ff    <= comp_en_in;
         main_en_ff    <= main_en_in;
         do_comm_ff    <= do_comm_in;
         do_spd_ff     <= do_spd_in;
         pm_mplier_ff  <= pm_mplier_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= bhc_pkg::PWM_PERIOD_RST;
         ppair_ff      <= bhc_pkg::PPAIR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bhc_pkg::CSR_PWM_PERIOD: pwm_period_ff <= csr_wdata;
            bhc_pkg::CSR_PPAIR:      ppair_ff      <= csr_wdata[bhc_pkg::PP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pm_acc_ff   <= pm_acc_in;
      pm_mcand_ff <= pm_mcand_in;
      pat_ff      <= pat_in;
      if (req_accept) begin
         cmd_ff  <= req_cmd;
         hall_ff <= req_hall_code;
         now_ff  <= req_timer_now;
         rev_ff  <= req_reverse;
         dsat_ff <= req_dsat;
      end
      if (out_load) begin
         o_run_ff    <= run_ff;
         o_cmp_u_ff  <= cmp_u_ff;
         o_cmp_v_ff  <= cmp_v_ff;
         o_cmp_w_ff  <= cmp_w_ff;
         o_gate_ff   <= gate_ff;
         o_comp_ff   <= comp_en_ff;
         o_main_ff   <= main_en_ff;
         o_speed_ff  <= speed_ff;
         o_period_ff <= period_ff;
         o_commut_ff <= commut_ff;
         o_fault_ff  <= fault_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_state_out   = o_run_ff;
   assign rsp_compare_u       = o_cmp_u_ff;
   assign rsp_compare_v       = o_cmp_v_ff;
   assign rsp_compare_w       = o_cmp_w_ff;
   assign rsp_gate_pattern    = o_gate_ff;
   assign rsp_comp_outputs_on = o_comp_ff;
   assign rsp_main_output_on  = o_main_ff;
   assign rsp_speed_rpm_out   = o_speed_ff;
   assign rsp_period_us_out   = o_period_ff;
   assign rsp_commutations    = o_commut_ff;
   assign rsp_faults          = o_fault_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (ctl_ff == bhc_pkg::CTL_EXEC))
      else $error("request accepted without entering execute");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == bhc_pkg::CTL_IDLE) |-> (!spd_rsp.busy && (pm_mplier_ff == '0)))
      else $error("arithmetic still busy while idle");

   a_commut_calc: assert property (@(posedge clock) disable iff (reset)
      !$stable(commut_ff) |-> ($past(ctl_ff) == bhc_pkg::CTL_CALC))
      else $error("commutation count moved outside calc");

   a_done_out: assert property (@(posedge clock) disable iff (reset)
      ((ctl_ff == bhc_pkg::CTL_DONE) && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished request not presented");

endmodule

`default_nettype wire

[verif/tb_bldc_hall_six_step_commutator_core.sv]
`timescale 1ns / 100ps

module tb_bldc_hall_six_step_commutator_core;

   localparam logic [2:0] CMD_UNUSED6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED7 = 3'd7;
   localparam logic [63:0] RPM_LIMIT = 64'd32767;
   // step patterns, hall code 7 at the left down to code 0 at the right
   localparam logic [7:0][5:0] FWD_STEPS =
      {6'h00, 6'h12, 6'h09, 6'h18, 6'h21, 6'h06, 6'h24, 6'h00};
   localparam logic [7:0][5:0] REV_STEPS =
      {6'h00, 6'h21, 6'h06, 6'h24, 6'h12, 6'h28, 6'h18, 6'h00};
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 205;

   typedef struct {
      logic [1:0]  run_state;
      logic [15:0] cmp_u;
      logic [15:0] cmp_v;
      logic [15:0] cmp_w;
      logic [5:0]  gates;
      logic        comp_on;
      logic        main_on;
      logic [15:0] speed;
      logic [31:0] period;
      logic [31:0] commutations;
      logic [31:0] faults;
   } snapshot_type;

   class scoreboard_type;
      logic [15:0] pwm_period;
      logic [7:0]  ppair;
      logic [1:0]  run_state;
      logic        dir_rev;
      logic [12:0] duty;
      logic [31:0] last_edge;
      logic        edge_seen;
      logic [31:0] period;
      logic [15:0] speed;
      logic [31:0] commutation_cnt;
      logic [31:0] fault_cnt;
      logic [15:0] cmp_val [3];
      logic [5:0]  gates;
      logic        comp_en;
      logic        main_en;
      snapshot_type expected_snaps [$];
      int          errors;

      function new();
         pwm_period = bhc_pkg::PWM_PERIOD_RST;
         ppair = bhc_pkg::PPAIR_RST;
         run_state = bhc_pkg::RUN_STOPPED;
         dir_rev = 1'b0;
         duty = '0;
         last_edge = '0;
         edge_seen = 1'b0;
         period = '0;
         speed = '0;
         commutation_cnt = '0;
         fault_cnt = '0;
         cmp_val = '{16'd0, 16'd0, 16'd0};
         gates = '0;
         comp_en = 1'b1;
         main_en = 1'b1;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] data);
         if (idx == bhc_pkg::CSR_PWM_PERIOD) pwm_period = data;
         else ppair = data[7:0];
      endfunction

      function void apply_step(logic [2:0] hall);
         logic [5:0]  pat;
         logic [28:0] prod;
         pat = dir_rev ? REV_STEPS[hall] : FWD_STEPS[hall];
         prod = 29'(duty) * 29'(pwm_period);
         for (int ph = 0; ph < 3; ph++)
            cmp_val[ph] = pat[5 - 2 * ph] ? prod[27:12] : 16'd0;
         gates = pat;
         commutation_cnt++;
      endfunction

      function void note_request(logic [2:0] cmd, logic [2:0] hall, logic [31:0] tnow,
                                 logic rev, logic [12:0] duty_in);
         logic [12:0] d;
         logic [31:0] diff;
         logic [63:0] pp;
         logic [63:0] rpm;
         snapshot_type s;
         d = (duty_in > bhc_pkg::DUTY_FULL) ? bhc_pkg::DUTY_FULL : duty_in;
         case (cmd)
            bhc_pkg::CMD_START: begin
               if (run_state != bhc_pkg::RUN_FAULT) begin
                  dir_rev = rev;
                  duty = d;
                  run_state = bhc_pkg::RUN_RUNNING;
                  comp_en = 1'b1;
                  apply_step(hall);
               end
            end
            bhc_pkg::CMD_STOP: begin
               run_state = bhc_pkg::RUN_STOPPED;
               duty = '0;
               cmp_val = '{16'd0, 16'd0, 16'd0};
               gates = '0;
               comp_en = 1'b0;
            end
            bhc_pkg::CMD_SET_DUTY: duty = d;
            bhc_pkg::CMD_HALL_EDGE: begin
               if (run_state == bhc_pkg::RUN_RUNNING) begin
                  if (edge_seen) begin
                     diff = tnow - last_edge;
                     period = diff;
                     if (diff != 0) begin
                        pp = (ppair == 0) ? 64'(bhc_pkg::PPAIR_DEF) : 64'(ppair);
                        rpm = 64'(bhc_pkg::RPM_NUMERATOR) / (64'(diff) * pp);
                        if (rpm > RPM_LIMIT) rpm = RPM_LIMIT;
                        speed = dir_rev ? 16'd0 - rpm[15:0] : rpm[15:0];
                     end
                  end
                  last_edge = tnow;
                  edge_seen = 1'b1;
                  apply_step(hall);
               end
            end
            bhc_pkg::CMD_BREAK: begin
               run_state = bhc_pkg::RUN_FAULT;
               fault_cnt++;
               speed = '0;
               duty = '0;
               main_en = 1'b0;
            end
            bhc_pkg::CMD_CLEAR: begin
               if (run_state == bhc_pkg::RUN_FAULT) begin
                  main_en = 1'b1;
                  run_state = bhc_pkg::RUN_STOPPED;
               end
            end
            default: begin
            end
         endcase
         s.run_state = run_state;
         s.cmp_u = cmp_val[0];
         s.cmp_v = cmp_val[1];
         s.cmp_w = cmp_val[2];
         s.gates = gates;
         s.comp_on = comp_en;
         s.main_on = main_en;
         s.speed = speed;
         s.period = period;
         s.commutations = commutation_cnt;
         s.faults = fault_cnt;
         expected_snaps.push_back(s);
      endfunction

      function void check_field(string name, logic signed [32:0] want,
                                logic signed [32:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(snapshot_type got);
         snapshot_type want;
         if (expected_snaps.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
         end
         want = expected_snaps.pop_front();
         check_field("run_state_out", 33'(want.run_state), 33'(got.run_state));
         check_field("compare_u", 33'(want.cmp_u), 33'(got.cmp_u));
         check_field("compare_v", 33'(want.cmp_v), 33'(got.cmp_v));
         check_field("compare_w", 33'(want.cmp_w), 33'(got.cmp_w));
         check_field("gate_pattern", 33'(want.gates), 33'(got.gates));
         check_field("comp_outputs_on", 33'(want.comp_on), 33'(got.comp_on));
         check_field("main_output_on", 33'(want.main_on), 33'(got.main_on));
         check_field("speed_rpm_out", 33'($signed(want.speed)), 33'($signed(got.speed)));
         check_field("period_us_out", 33'(want.period), 33'(got.period));
         check_field("commutations", 33'(want.commutations), 33'(got.commutations));
         check_field("faults", 33'(want.faults), 33'(got.faults));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_cmd;
   logic [2:0] req_hall_code;
   logic [31:0] req_timer_now;
   logic req_reverse;
   logic [12:0] req_duty_in;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_run_state_out;
   logic [15:0] rsp_compare_u;
   logic [15:0] rsp_compare_v;
   logic [15:0] rsp_compare_w;
   logic [5:0] rsp_gate_pattern;
   logic rsp_comp_outputs_on;
   logic rsp_main_output_on;
   logic signed [15:0] rsp_speed_rpm_out;
   logic [31:0] rsp_period_us_out;
   logic [31:0] rsp_commutations;
   logic [31:0] rsp_faults;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [15:0] csr_wdata;

   scoreboard_type sb;
   int gap_pct;
   int stall_pct;
   int sent_items;
   logic [31:0] timer_base;

   bldc_hall_six_step_commutator_core DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      snapshot_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.run_state = rsp_run_state_out;
            got.cmp_u = rsp_compare_u;
            got.cmp_v = rsp_compare_v;
            got.cmp_w = rsp_compare_w;
            got.gates = rsp_gate_pattern;
            got.comp_on = rsp_comp_outputs_on;
            got.main_on = rsp_main_output_on;
            got.speed = rsp_speed_rpm_out;
            got.period = rsp_period_us_out;
            got.commutations = rsp_commutations;
            got.faults = rsp_faults;
            sb.check_response(got);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(input logic [2:0] cmd, input logic [2:0] hall,
                               input logic [31:0] tnow, input logic rev,
                               input logic [12:0] duty);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_hall_code <= hall;
      req_timer_now <= tnow;
      req_reverse <= rev;
      req_duty_in <= duty;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, hall, tnow, rev, duty);
      sent_items++;
   endtask

   task automatic random_request();
      logic [2:0]  cmd;
      logic [2:0]  hall;
      logic [31:0] delta;
      logic [12:0] duty;
      int          pick;
      int          r;
      pick = $urandom_range(99);
      if (sb.run_state == bhc_pkg::RUN_FAULT && pick < 50) cmd = bhc_pkg::CMD_CLEAR;
      else if (sb.run_state == bhc_pkg::RUN_FAULT && pick < 60) cmd = bhc_pkg::CMD_STOP;
      else if (sb.run_state == bhc_pkg::RUN_STOPPED && pick < 50) cmd = bhc_pkg::CMD_START;
      else begin
         pick = $urandom_range(99);
         if (pick < 6) cmd = bhc_pkg::CMD_START;
         else if (pick < 10) cmd = bhc_pkg::CMD_STOP;
         else if (pick < 20) cmd = bhc_pkg::CMD_SET_DUTY;
         else if (pick < 22) cmd = bhc_pkg::CMD_BREAK;
         else if (pick < 24) cmd = bhc_pkg::CMD_CLEAR;
         else if (pick < 26) cmd = $urandom_range(1) ? CMD_UNUSED7 : CMD_UNUSED6;
         else cmd = bhc_pkg::CMD_HALL_EDGE;
      end
      hall = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : 3'($urandom_range(6, 1));
      r = $urandom_range(99);
      if (r < 3) delta = '0;
      else if (r < 30) delta = $urandom_range(400, 1);
      else if (r < 85) delta = $urandom_range(200000, 400);
      else delta = $urandom;
      if (r >= 95) timer_base = $urandom;
      else timer_base = timer_base + delta;
      duty = ($urandom_range(99) < 10) ? 13'($urandom_range(8191)) : 13'($urandom_range(4096));
      send_request(cmd, hall, timer_base, 1'($urandom_range(1)), duty);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_snaps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] pwm, input logic [15:0] pp);
      csr_valid <= 1'b1;
      csr_index <= bhc_pkg::CSR_PWM_PERIOD;
      csr_wdata <= pwm;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(bhc_pkg::CSR_PWM_PERIOD, pwm);
      csr_index <= bhc_pkg::CSR_PPAIR;
      csr_wdata <= pp;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(bhc_pkg::CSR_PPAIR, pp);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [15:0] pwm_set [RANDOM_PHASES];
      logic [15:0] pp_set [RANDOM_PHASES];
      int gap_set [RANDOM_PHASES];
      int stall_set [RANDOM_PHASES];
      int target;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= bhc_pkg::CMD_START;
      req_hall_code <= '0;
      req_timer_now <= '0;
      req_reverse <= 1'b0;
      req_duty_in <= '0;
      csr_valid <= 1'b0;
      csr_index <= bhc_pkg::CSR_PWM_PERIOD;
      csr_wdata <= '0;
      gap_pct = 0;
      stall_pct = 0;
      sent_items = 0;
      timer_base = '0;
      pwm_set = '{16'd1000, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(65535, 2))};
      pp_set = '{16'd4, 16'h00FF, 16'h5A01, 16'hA500, 16'($urandom)};
      gap_set = '{0, 80, 0, 8, 0};
      stall_set = '{0, 0, 80, 8, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed sequence at reset configuration
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd1, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_CLEAR, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(CMD_UNUSED6, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(CMD_UNUSED7, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_SET_DUTY, 3'd0, 32'd0, 1'b0, 13'h1FFF);
      send_request(bhc_pkg::CMD_START, 3'd1, 32'd0, 1'b0, bhc_pkg::DUTY_FULL);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd2, 32'hFFFF_FF00, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd3, 32'hFFFF_FF00, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd0, 32'h0000_0010, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd7, 32'h0000_0011, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_SET_DUTY, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd4, 32'hFFFF_FFFF, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_SET_DUTY, 3'd0, 32'd0, 1'b0, 13'd2048);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd5, 32'd5000, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd6, 32'd9000, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_STOP, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_START, 3'd6, 32'd0, 1'b1, 13'd4095);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd5, 32'd10000, 1'b1, 13'd0);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd3, 32'd10001, 1'b1, 13'd0);
      send_request(bhc_pkg::CMD_BREAK, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_START, 3'd1, 32'd0, 1'b0, 13'd100);
      send_request(bhc_pkg::CMD_HALL_EDGE, 3'd2, 32'd20000, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_CLEAR, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_BREAK, 3'd0, 32'd0, 1'b0, 13'd0);
      send_request(bhc_pkg::CMD_STOP, 3'd0, 32'd0, 1'b0, 13'd0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         write_config(pwm_set[ph], pp_set[ph]);
         gap_pct = gap_set[ph];
         stall_pct = stall_set[ph];
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) random_request();
      end

      drain();
      if (sb.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
